### design/orm_pkg.sv
`timescale 1ns / 1ps

package orm_pkg;

    localparam int C_COORD_BITS = 16;
    localparam int C_CFG_IDX_BITS = 2;
    localparam int C_CFG_DATA_BITS = 16;
    localparam int C_TDATA_BITS = 4 * C_COORD_BITS;

    typedef logic [C_COORD_BITS-1:0] t_coord;

    typedef enum logic [2:0] {
        ORIENT_NORMAL      = 3'd0,
        ORIENT_ROT90       = 3'd1,
        ORIENT_ROT180      = 3'd2,
        ORIENT_ROT270      = 3'd3,
        ORIENT_FLIP        = 3'd4,
        ORIENT_FLIP_ROT90  = 3'd5,
        ORIENT_FLIP_ROT180 = 3'd6,
        ORIENT_FLIP_ROT270 = 3'd7
    } t_orient;

    typedef enum logic [C_CFG_IDX_BITS-1:0] {
        CFG_NATIVE_WIDTH  = 2'd0,
        CFG_NATIVE_HEIGHT = 2'd1,
        CFG_ORIENTATION   = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    typedef struct packed {
        t_coord  native_w;
        t_coord  native_h;
        t_orient orient;
    } t_cfg;

    typedef struct packed {
        logic   cmd;
        t_coord x;
        t_coord y;
        t_coord w;
        t_coord h;
    } t_in_word;

    typedef struct packed {
        logic   ok;
        logic   cmd;
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
    } t_bnd_word;

    typedef struct packed {
        logic   ok;
        t_coord cx0;
        t_coord cy0;
        t_coord cx1;
        t_coord cy1;
    } t_map_word;

    typedef struct packed {
        logic   ok;
        t_coord x;
        t_coord y;
        t_coord w;
        t_coord h;
    } t_out_word;

endpackage

### design/orm_bounds.sv
`timescale 1ns / 1ps

module orm_bounds import orm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_bnd_word o_word
);

    logic                  r_valid;
    t_bnd_word             r_word;
    t_bnd_word             n_word;
    t_coord                ext_w;
    t_coord                ext_h;
    logic [C_COORD_BITS:0] sum_x;
    logic [C_COORD_BITS:0] sum_y;

    always_comb begin
        if (i_word.cmd == CMD_FORWARD && i_cfg.orient[0]) begin
            ext_w = i_cfg.native_h;
            ext_h = i_cfg.native_w;
        end else begin
            ext_w = i_cfg.native_w;
            ext_h = i_cfg.native_h;
        end
        sum_x = {1'b0, i_word.x} + {1'b0, i_word.w};
        sum_y = {1'b0, i_word.y} + {1'b0, i_word.h};
        n_word.ok  = (sum_x <= {1'b0, ext_w}) && (sum_y <= {1'b0, ext_h});
        n_word.cmd = i_word.cmd;
        n_word.x0  = i_word.x;
        n_word.y0  = i_word.y;
        n_word.x1  = sum_x[C_COORD_BITS-1:0];
        n_word.y1  = sum_y[C_COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### design/orm_map.sv
`timescale 1ns / 1ps

module orm_map import orm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_bnd_word i_word,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_map_word o_word
);

    // Each mapped axis depends on one source axis only, so the opposite
    // corners of the rectangle bound the mapped box.
    function automatic logic [2*C_COORD_BITS-1:0] map_point(
        input logic    inverse,
        input t_orient orient,
        input t_coord  w,
        input t_coord  h,
        input t_coord  a,
        input t_coord  b
    );
        t_coord x;
        t_coord y;
        x = a;
        y = b;
        if (!inverse) begin
            case (orient)
                ORIENT_NORMAL: begin
                    x = a;     y = b;
                end
                ORIENT_ROT90: begin
                    x = w - b; y = a;
                end
                ORIENT_ROT180: begin
                    x = w - a; y = h - b;
                end
                ORIENT_ROT270: begin
                    x = b;     y = h - a;
                end
                ORIENT_FLIP: begin
                    x = w - a; y = b;
                end
                ORIENT_FLIP_ROT90: begin
                    x = w - b; y = h - a;
                end
                ORIENT_FLIP_ROT180: begin
                    x = a;     y = h - b;
                end
                default: begin
                    x = b;     y = a;
                end
            endcase
        end else begin
            case (orient)
                ORIENT_NORMAL: begin
                    x = a;     y = b;
                end
                ORIENT_ROT90: begin
                    x = b;     y = w - a;
                end
                ORIENT_ROT180: begin
                    x = w - a; y = h - b;
                end
                ORIENT_ROT270: begin
                    x = h - b; y = a;
                end
                ORIENT_FLIP: begin
                    x = w - a; y = b;
                end
                ORIENT_FLIP_ROT90: begin
                    x = h - b; y = w - a;
                end
                ORIENT_FLIP_ROT180: begin
                    x = a;     y = h - b;
                end
                default: begin
                    x = b;     y = a;
                end
            endcase
        end
        return {x, y};
    endfunction

    logic      r_valid;
    t_map_word r_word;
    t_map_word n_word;

    always_comb begin
        n_word.ok = i_word.ok;
        {n_word.cx0, n_word.cy0} = map_point(i_word.cmd, i_cfg.orient, i_cfg.native_w,
                                             i_cfg.native_h, i_word.x0, i_word.y0);
        {n_word.cx1, n_word.cy1} = map_point(i_word.cmd, i_cfg.orient, i_cfg.native_w,
                                             i_cfg.native_h, i_word.x1, i_word.y1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### design/orm_box.sv
`timescale 1ns / 1ps

module orm_box import orm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_map_word i_word,
    output logic      o_valid,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word;
    t_out_word n_word;
    t_coord    min_x;
    t_coord    max_x;
    t_coord    min_y;
    t_coord    max_y;

    always_comb begin
        if (i_word.cx1 < i_word.cx0) begin
            min_x = i_word.cx1;
            max_x = i_word.cx0;
        end else begin
            min_x = i_word.cx0;
            max_x = i_word.cx1;
        end
        if (i_word.cy1 < i_word.cy0) begin
            min_y = i_word.cy1;
            max_y = i_word.cy0;
        end else begin
            min_y = i_word.cy0;
            max_y = i_word.cy1;
        end
        if (i_word.ok) begin
            n_word.ok = 1'b1;
            n_word.x  = min_x;
            n_word.y  = min_y;
            n_word.w  = max_x - min_x;
            n_word.h  = max_y - min_y;
        end else begin
            n_word = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### design/output_orientation_rect_mapper_top.sv
`timescale 1ns / 1ps

// Maps a rectangle (or a point, as a zero-size rectangle) between transformed output space
// and native panel space under one of eight rotate or flip orientations. A word is taken
// every cycle unless every stage is full and the output is held. One register stage
// checks the rectangle against the extent, one maps two opposite corners, and the output
// register forms the bounding box. A stalled output holds the pipeline back one stage at a
// time, so a word is taken whenever any stage is free. A rectangle outside the extent gives
// ok low with all coordinates zero. Write the configuration only while the block is idle.

module output_orientation_rect_mapper_top import orm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [C_CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [C_CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // rect_x, rect_y, rect_w, rect_h
    input  logic [C_TDATA_BITS-1:0]    s_axis_tdata,
    // cmd
    input  logic [0:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // out_x, out_y, out_w, out_h
    output logic [C_TDATA_BITS-1:0]    m_axis_tdata,
    // ok
    output logic [0:0]                 m_axis_tuser
);

    t_cfg      r_cfg;
    t_in_word  in_word;
    t_bnd_word bnd_word;
    t_map_word map_word;
    t_out_word out_word;
    logic      bnd_valid;
    logic      map_valid;
    logic      out_valid;
    logic      adv_bnd;
    logic      adv_map;
    logic      adv_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{native_w: '0, native_h: '0, orient: ORIENT_NORMAL};
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_NATIVE_WIDTH:  r_cfg.native_w <= i_cfg_data[C_COORD_BITS-1:0];
                CFG_NATIVE_HEIGHT: r_cfg.native_h <= i_cfg_data[C_COORD_BITS-1:0];
                CFG_ORIENTATION:   r_cfg.orient   <= t_orient'(i_cfg_data[2:0]);
                default: begin
                end
            endcase
        end
    end

    assign in_word.cmd = s_axis_tuser[0];
    assign in_word.x   = s_axis_tdata[C_COORD_BITS-1:0];
    assign in_word.y   = s_axis_tdata[2*C_COORD_BITS-1:C_COORD_BITS];
    assign in_word.w   = s_axis_tdata[3*C_COORD_BITS-1:2*C_COORD_BITS];
    assign in_word.h   = s_axis_tdata[4*C_COORD_BITS-1:3*C_COORD_BITS];

    assign adv_out = !out_valid || m_axis_tready;
    assign adv_map = !map_valid || adv_out;
    assign adv_bnd = !bnd_valid || adv_map;
    assign s_axis_tready = adv_bnd;

    orm_bounds u_bounds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_bnd),
        .i_valid (s_axis_tvalid),
        .i_word  (in_word),
        .i_cfg   (r_cfg),
        .o_valid (bnd_valid),
        .o_word  (bnd_word)
    );

    orm_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_map),
        .i_valid (bnd_valid),
        .i_word  (bnd_word),
        .i_cfg   (r_cfg),
        .o_valid (map_valid),
        .o_word  (map_word)
    );

    orm_box u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_out),
        .i_valid (map_valid),
        .i_word  (map_word),
        .o_valid (out_valid),
        .o_word  (out_word)
    );

    assign m_axis_tvalid   = out_valid;
    assign m_axis_tuser[0] = out_word.ok;
    assign m_axis_tdata    = {out_word.h, out_word.w, out_word.y, out_word.x};

    // The input side stalls only when every stage is full and the output is held.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (bnd_valid && map_valid && out_valid && !m_axis_tready))
        else $error("input stalled while a stage was free");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> bnd_valid)
        else $error("accepted word did not reach the first stage");

    a_reject_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("out-of-bounds result carries nonzero coordinates");

    a_box_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (({1'b0, out_word.x} + {1'b0, out_word.w}) <= {1'b0, {C_COORD_BITS{1'b1}}}))
        else $error("mapped box extends past the coordinate range");

endmodule
